// ===== rtl/gap_buffer_text_store_macros.svh =====
// Assertion macros for the gap buffer text store.
// Clocked on clk, disabled during rst; compiled out with NO_ASSERTIONS.
`ifndef GAP_BUFFER_TEXT_STORE_MACROS_SVH
`define GAP_BUFFER_TEXT_STORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GBTS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define GBTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define GBTS_ASSERT(label, cond, msg)
`define GBTS_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

// ===== rtl/gbts_pkg.sv =====
// Package for the gap buffer text store: sizes, request/response types,
// request and status codes, UTF-8 lead byte decode. No dependencies.
`timescale 1ns / 1ps

package gbts_pkg;

  localparam int CAPACITY    = 4096;
  localparam int GAP_GROW    = 16;
  localparam int INITIAL_GAP = 16;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int POS_W       = 13;
  localparam int BYTE_W      = 8;

  localparam logic [1:0] REQ_INSERT   = 2'd0;
  localparam logic [1:0] REQ_DEL_ONE  = 2'd1;
  localparam logic [1:0] REQ_DEL_MANY = 2'd2;
  localparam logic [1:0] REQ_READ     = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] data_byte;
    logic [POS_W-1:0]  char_count;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0]  new_position;
    logic [BYTE_W-1:0] read_byte;
    logic [POS_W-1:0]  text_length_out;
    logic [1:0]        status;
  } rsp_t;

  // Byte count of a UTF-8 character from its lead byte; bad leads count as one.
  function automatic logic [2:0] char_bytes(input logic [BYTE_W-1:0] lead);
    logic [2:0] n;
    if ((lead & 8'h80) == 8'h00) begin
      n = 3'd1;
    end else if ((lead & 8'hE0) == 8'hC0) begin
      n = 3'd2;
    end else if ((lead & 8'hF0) == 8'hE0) begin
      n = 3'd3;
    end else if ((lead & 8'hF8) == 8'hF0) begin
      n = 3'd4;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

endpackage

// ===== rtl/gbts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/gap_buffer_text_store.sv =====
// Gap buffer text store top level; uses gbts_pkg, gbts_ram and the assertion macros.
// One request in flight. Ignored or full go straight to S_DONE; a read fetches a byte; an
// insert moves the gap, grows it if empty and writes; a delete moves it and drops characters.
// A gap move copies bytes between gap and position, a grow the tail bytes. A new request is
// taken the cycle after its response is loaded; a stalled response holds the block in S_DONE.
// Reset: synchronous, resets pointers and control; store contents are not cleared.
`timescale 1ns / 1ps
`include "gap_buffer_text_store_macros.svh"

module gap_buffer_text_store
  import gbts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_MOVE    = 4'd2;
  localparam logic [3:0] S_COPY    = 4'd3;
  localparam logic [3:0] S_GROW    = 4'd4;
  localparam logic [3:0] S_WRITE   = 4'd5;
  localparam logic [3:0] S_DROP_RD = 4'd6;
  localparam logic [3:0] S_DROP_WT = 4'd7;
  localparam logic [3:0] S_READ_WT = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]        state;
  logic [3:0]        cp_ret;
  logic [1:0]        op;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  count;
  logic [BYTE_W-1:0] ins_byte;
  logic [POS_W-1:0]  gap_start;
  logic [POS_W-1:0]  gap_end;
  logic [POS_W-1:0]  text_length;
  logic [ADDR_W-1:0] cp_src;
  logic [ADDR_W-1:0] cp_dst;
  logic [POS_W-1:0]  cp_rem;
  logic              cp_down;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic [1:0]        res_status;
  logic [BYTE_W-1:0] res_byte;
  logic              res_step;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;

  logic [POS_W-1:0]  tail;
  logic [POS_W-1:0]  gap_span;
  logic [2:0]        lead_len;
  logic [POS_W-1:0]  drop_len;
  logic [POS_W-1:0]  read_phys;
  logic [3:0]        after_move;

  assign req_ready  = (state == S_IDLE);
  assign tail       = text_length - gap_start;
  assign gap_span   = gap_end - gap_start;
  assign lead_len   = char_bytes(rd_data);
  assign drop_len   = (tail < POS_W'(lead_len)) ? tail : POS_W'(lead_len);
  assign read_phys  = (pos < gap_start) ? pos : pos + gap_span;
  assign after_move = (op == REQ_INSERT) ? S_GROW : S_DROP_RD;

  gbts_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(CAPACITY)
  ) u_byte_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cp_src;
    wr_en   = 1'b0;
    wr_addr = pend_addr;
    wr_data = rd_data;
    unique case (state)
      S_DECODE: begin
        rd_en   = (op == REQ_READ);
        rd_addr = read_phys[ADDR_W-1:0];
      end
      S_COPY: begin
        rd_en = (cp_rem != '0);
        wr_en = pend;
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = gap_start[ADDR_W-1:0];
        wr_data = ins_byte;
      end
      S_DROP_RD: begin
        rd_en   = 1'b1;
        rd_addr = gap_end[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      pend        <= 1'b0;
      gap_start   <= '0;
      gap_end     <= POS_W'(INITIAL_GAP);
      text_length <= '0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op         <= req.req_type;
            pos        <= req.position;
            ins_byte   <= req.data_byte;
            count      <= req.char_count;
            res_status <= ST_DONE;
            res_byte   <= '0;
            res_step   <= 1'b0;
            state      <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (op)
            REQ_INSERT: begin
              if (pos > text_length) begin
                res_status <= ST_IGNORED;
                state      <= S_DONE;
              end else if (text_length >= POS_W'(CAPACITY - GAP_GROW)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                state <= S_MOVE;
              end
            end
            REQ_DEL_ONE: begin
              if (pos >= text_length) begin
                res_status <= ST_IGNORED;
                state      <= S_DONE;
              end else begin
                count <= POS_W'(1);
                state <= S_MOVE;
              end
            end
            REQ_DEL_MANY: begin
              if ({1'b0, pos} + {1'b0, count} >= {1'b0, text_length}) begin
                res_status <= ST_IGNORED;
                state      <= S_DONE;
              end else begin
                state <= S_MOVE;
              end
            end
            REQ_READ: begin
              if (pos >= text_length) begin
                res_status <= ST_IGNORED;
                state      <= S_DONE;
              end else begin
                state <= S_READ_WT;
              end
            end
          endcase
        end
        S_READ_WT: begin
          res_byte <= rd_data;
          state    <= S_DONE;
        end
        S_MOVE: begin
          if (pos == gap_start) begin
            state <= after_move;
          end else if (gap_start == gap_end) begin
            gap_start <= pos;
            gap_end   <= pos;
            state     <= after_move;
          end else if (pos < gap_start) begin
            cp_src    <= gap_start[ADDR_W-1:0] - 1'b1;
            cp_dst    <= gap_end[ADDR_W-1:0] - 1'b1;
            cp_rem    <= gap_start - pos;
            cp_down   <= 1'b1;
            gap_start <= pos;
            gap_end   <= gap_end - (gap_start - pos);
            cp_ret    <= after_move;
            state     <= S_COPY;
          end else begin
            cp_src    <= gap_end[ADDR_W-1:0];
            cp_dst    <= gap_start[ADDR_W-1:0];
            cp_rem    <= pos - gap_start;
            cp_down   <= 1'b0;
            gap_start <= pos;
            gap_end   <= gap_end + (pos - gap_start);
            cp_ret    <= after_move;
            state     <= S_COPY;
          end
        end
        S_COPY: begin
          // read issued this cycle is written in the next cycle at the saved dest
          if (cp_rem != '0) begin
            cp_src    <= cp_down ? cp_src - 1'b1 : cp_src + 1'b1;
            cp_dst    <= cp_down ? cp_dst - 1'b1 : cp_dst + 1'b1;
            cp_rem    <= cp_rem - 1'b1;
            pend_addr <= cp_dst;
            pend      <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= cp_ret;
            end
          end
        end
        S_GROW: begin
          if (gap_start == gap_end) begin
            cp_src  <= text_length[ADDR_W-1:0] - 1'b1;
            cp_dst  <= text_length[ADDR_W-1:0] + ADDR_W'(GAP_GROW - 1);
            cp_rem  <= tail;
            cp_down <= 1'b1;
            gap_end <= gap_end + POS_W'(GAP_GROW);
            cp_ret  <= S_WRITE;
            state   <= S_COPY;
          end else begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          gap_start   <= gap_start + 1'b1;
          text_length <= text_length + 1'b1;
          res_step    <= 1'b1;
          state       <= S_DONE;
        end
        S_DROP_RD: begin
          if (count != '0 && text_length > gap_start) begin
            state <= S_DROP_WT;
          end else begin
            state <= S_DONE;
          end
        end
        S_DROP_WT: begin
          gap_end     <= gap_end + drop_len;
          text_length <= text_length - drop_len;
          count       <= count - 1'b1;
          state       <= S_DROP_RD;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid           <= 1'b1;
            rsp.new_position    <= res_step ? pos + 1'b1 : pos;
            rsp.read_byte       <= res_byte;
            rsp.text_length_out <= text_length;
            rsp.status          <= res_status;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GBTS_ASSERT(a_gap_order, gap_start <= gap_end, "gap start passed gap end")
  `GBTS_ASSERT(a_gap_in_text, gap_start <= text_length, "gap start beyond text")
  `GBTS_ASSERT(a_len_bound, text_length <= POS_W'(CAPACITY - GAP_GROW), "text too long")
  `GBTS_ASSERT(a_phys_fit, ({1'b0, gap_end} + {1'b0, tail}) <= (POS_W + 1)'(CAPACITY), "overrun")
  `GBTS_ASSERT_IMPL(a_no_clash, pend && cp_rem != '0, pend_addr != cp_src, "copy clash")

endmodule

// ===== tb/tb_gap_buffer_text_store.sv =====
// Self-checking testbench for gap_buffer_text_store: drives insert/delete/read requests and
// checks every response against a logical text predictor. Depends on gbts_pkg and the RTL.
`timescale 1ns / 1ps

module tb_gap_buffer_text_store
  import gbts_pkg::*;
();

  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // logical view of the stored text
  logic [7:0] text_mem [0:CAPACITY-1];
  int text_len = 0;

  rsp_t expected_rsp_q[$];
  rsp_t want_rsp;
  int mismatch_count = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  gap_buffer_text_store uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #1 clk = ~clk;

  function automatic int char_len(input logic [7:0] lead);
    int n;
    casez (lead)
      8'b0???????: n = 1;
      8'b110?????: n = 2;
      8'b1110????: n = 3;
      8'b11110???: n = 4;
      default:     n = 1;
    endcase
    return n;
  endfunction

  function automatic void drop_chars(input int at, input int chars);
    int n;
    int k;
    while (chars > 0 && text_len > at) begin
      n = char_len(text_mem[at]);
      if (n > text_len - at) n = text_len - at;
      for (k = at; k + n < text_len; k++) text_mem[k] = text_mem[k + n];
      text_len -= n;
      chars--;
    end
  endfunction

  function automatic rsp_t apply_edit(input req_t r);
    rsp_t o;
    int p;
    int cnt;
    int k;
    p = int'(r.position);
    cnt = int'(r.char_count);
    o.new_position = r.position;
    o.read_byte = '0;
    o.status = ST_DONE;
    case (r.req_type)
      REQ_INSERT: begin
        if (p > text_len) begin
          o.status = ST_IGNORED;
        end else if (text_len + GAP_GROW >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          for (k = text_len; k > p; k--) text_mem[k] = text_mem[k - 1];
          text_mem[p] = r.data_byte;
          text_len++;
          o.new_position = POS_W'(p + 1);
        end
      end
      REQ_DEL_ONE: begin
        if (p >= text_len) o.status = ST_IGNORED;
        else drop_chars(p, 1);
      end
      REQ_DEL_MANY: begin
        if (p + cnt >= text_len) o.status = ST_IGNORED;
        else drop_chars(p, cnt);
      end
      default: begin
        if (p >= text_len) o.status = ST_IGNORED;
        else o.read_byte = text_mem[p];
      end
    endcase
    o.text_length_out = POS_W'(text_len);
    return o;
  endfunction

  function automatic req_t pack_req(input logic [1:0] kind, input int pos, input int data,
                                    input int count);
    req_t r;
    r.req_type = kind;
    r.position = POS_W'(pos);
    r.data_byte = BYTE_W'(data);
    r.char_count = POS_W'(count);
    return r;
  endfunction

  function automatic int random_text_byte();
    int b;
    case ($urandom_range(5)) inside
      [0:1]:   b = $urandom_range(127);
      2:       b = 8'hC0 + $urandom_range(31);
      3:       b = 8'hE0 + $urandom_range(15);
      4:       b = 8'hF0 + $urandom_range(7);
      default: b = $urandom_range(255);
    endcase
    return b;
  endfunction

  // mostly well-formed edits around the current text, some noise
  function automatic req_t random_edit();
    req_t r;
    int pick;
    int ins_w;
    int pos;
    r = pack_req(2'($urandom_range(3)), $urandom_range(8191), $urandom_range(255),
                 $urandom_range(8191));
    pick = $urandom_range(99);
    ins_w = (text_len > 160) ? 20 : 50;
    if (pick < 8) begin
      return r;
    end else if (pick < 8 + ins_w) begin
      r.req_type = REQ_INSERT;
      r.position = POS_W'(($urandom_range(9) == 0) ? text_len + 1 : $urandom_range(text_len));
      r.data_byte = BYTE_W'(random_text_byte());
    end else if (pick < 8 + ins_w + 15) begin
      r.req_type = REQ_DEL_ONE;
      r.position = POS_W'($urandom_range(text_len));
    end else if (pick < 8 + ins_w + 30) begin
      r.req_type = REQ_DEL_MANY;
      pos = (text_len > 0) ? $urandom_range(text_len - 1) : 0;
      r.position = POS_W'(pos);
      r.char_count = POS_W'(($urandom_range(7) == 0) ? text_len - pos : $urandom_range(4));
    end else begin
      r.req_type = REQ_READ;
      r.position = POS_W'($urandom_range(text_len));
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    expected_rsp_q.push_back(apply_edit(r));
  endtask

  task automatic wait_results_drained();
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_edges();
    logic [7:0] seed_text [0:12];
    int k;
    seed_text = '{8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
                  8'hFF, 8'h00, 8'hF0};
    send_request(pack_req(REQ_READ, 0, 0, 0));
    send_request(pack_req(REQ_DEL_ONE, 0, 0, 0));
    send_request(pack_req(REQ_DEL_MANY, 0, 0, 0));
    send_request(pack_req(REQ_INSERT, 1, 'h55, 0));
    for (k = 0; k < 13; k++) begin
      send_request(pack_req(REQ_INSERT, text_len, int'(seed_text[k]), 0));
    end
    send_request(pack_req(REQ_INSERT, 0, 'h7F, 8191));
    send_request(pack_req(REQ_READ, 2, 'hFF, 0));
    send_request(pack_req(REQ_READ, 8191, 0, 8191));
    // truncated 4-byte char at the tail
    send_request(pack_req(REQ_DEL_ONE, text_len - 1, 0, 0));
    send_request(pack_req(REQ_DEL_ONE, 2, 0, 0));
    send_request(pack_req(REQ_DEL_MANY, 0, 0, 0));
    send_request(pack_req(REQ_DEL_MANY, 1, 0, 3));
    send_request(pack_req(REQ_DEL_MANY, 0, 0, text_len));
    send_request(pack_req(REQ_DEL_MANY, 8191, 'hFF, 8191));
    send_request(pack_req(REQ_INSERT, 8191, 'hFF, 0));
  endtask

  task automatic test_random_edits(input int n_items);
    int k;
    for (k = 0; k < n_items; k++) begin
      send_request(random_edit());
      if (k % 16 == 15) wait_results_drained();
    end
  endtask

  task automatic test_text_bounds();
    send_request(pack_req(REQ_INSERT, text_len, 'h41, 0));
    send_request(pack_req(REQ_INSERT, 0, 'h42, 0));
    send_request(pack_req(REQ_INSERT, text_len + 1, 'h43, 0));
    send_request(pack_req(REQ_READ, 0, 0, 0));
    send_request(pack_req(REQ_READ, text_len - 1, 0, 0));
    send_request(pack_req(REQ_READ, text_len, 0, 0));
    send_request(pack_req(REQ_DEL_ONE, 0, 0, 0));
    send_request(pack_req(REQ_INSERT, 0, 'hC3, 0));
    send_request(pack_req(REQ_DEL_MANY, 100, 0, 40));
    send_request(pack_req(REQ_READ, 100, 0, 0));
    send_request(pack_req(REQ_INSERT, text_len, 'hE2, 0));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected response: pos=%0d byte=%h len=%0d st=%0d",
                     rsp.new_position, rsp.read_byte, rsp.text_length_out, rsp.status);
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          if (rsp.new_position !== want_rsp.new_position ||
              rsp.read_byte !== want_rsp.read_byte ||
              rsp.text_length_out !== want_rsp.text_length_out ||
              rsp.status !== want_rsp.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: exp pos=%0d byte=%h len=%0d st=%0d, ",
                        "got pos=%0d byte=%h len=%0d st=%0d"},
                       want_rsp.new_position, want_rsp.read_byte, want_rsp.text_length_out,
                       want_rsp.status, rsp.new_position, rsp.read_byte,
                       rsp.text_length_out, rsp.status);
          end
        end
      end
      rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_gap_buffer_text_store: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle_pct = 17;
    sink_idle_pct = 86;
    test_directed_edges();
    test_random_edits(34);
    wait_results_drained();
    src_idle_pct = 86;
    sink_idle_pct = 17;
    test_random_edits(34);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_edits(34);
    test_text_bounds();
    wait_results_drained();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
      $display("tb_gap_buffer_text_store: PASS");
    end else begin
      $display("tb_gap_buffer_text_store: FAIL");
    end
    $finish;
  end

endmodule
